### rtl/ttcs_pkg.sv
// shared types and constants for the text terminal with cursor and scroll
// no dependencies; used by every module of the block by scoped names
package ttcs_pkg;

   localparam int COLUMNS = 40;
   localparam int ROWS    = 24;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int CNT_W   = $clog2(CELLS + 1);
   localparam int COL_W   = 6;
   localparam int ROW_W   = 5;

   localparam logic [1:0] ACT_PRINT = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_CURSOR = 8'hFF;
   localparam logic [7:0] GLYPH_ON  = 8'hFE;
   localparam logic [7:0] GLYPH_OFF = 8'h20;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] char_code;
      logic       advance;
      logic [9:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [7:0]       cell_data;
      logic [COL_W-1:0] cursor_column;
      logic [ROW_W-1:0] cursor_row;
      logic             scrolled;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

### rtl/ttcs_charmem.sv
// character buffer: one write port, one read port, registered read data
// depends on ttcs_pkg for depth and the port struct
module ttcs_charmem (
   input  logic                 clock,
   input  ttcs_pkg::mem_req_type mem_req,
   output logic [7:0]           rd_data
);

   logic [7:0] char_mem_ff [ttcs_pkg::CELLS];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         char_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= char_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ttcs_ctrl.sv
// sequencer: cursor registers, byte decode, scroll copy and clear sweeps
// depends on ttcs_pkg; drives the ttcs_charmem ports
module ttcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ttcs_pkg::req_type     req_data,
   input  logic                  show_cursor,
   input  logic                  out_free,
   output logic                  done_valid,
   output ttcs_pkg::rsp_type     done_data,
   output ttcs_pkg::mem_req_type mem_req,
   input  logic [7:0]            rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY,
      ST_BOTTOM,
      ST_CLEAR,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [ttcs_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ttcs_pkg::COL_W-1:0]     col_ff, col_in;
   logic [ttcs_pkg::ROW_W-1:0]     row_ff, row_in;
   logic                           scr_ff, scr_in;
   logic                           hit_ff, hit_in;
   logic                           emit_ff, emit_in;

   logic [ttcs_pkg::ADDR_W-1:0]    cursor_pos;
   logic [ttcs_pkg::CNT_W-1:0]     copy_dst;
   logic                           last_row;
   logic                           last_col;

   assign cursor_pos = ttcs_pkg::ADDR_W'(ttcs_pkg::ADDR_W'(row_ff)
                     * ttcs_pkg::ADDR_W'(ttcs_pkg::COLUMNS)
                     + ttcs_pkg::ADDR_W'(col_ff));
   assign last_row = ((ttcs_pkg::ROW_W + 1)'(row_ff) + (ttcs_pkg::ROW_W + 1)'(1))
                     >= (ttcs_pkg::ROW_W + 1)'(ttcs_pkg::ROWS);
   assign last_col = ((ttcs_pkg::COL_W + 1)'(col_ff) + (ttcs_pkg::COL_W + 1)'(1))
                     >= (ttcs_pkg::COL_W + 1)'(ttcs_pkg::COLUMNS);
   // copy writes trail the reads by one line plus the read latency
   assign copy_dst = cnt_ff - ttcs_pkg::CNT_W'(ttcs_pkg::COLUMNS + 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      scr_in   = scr_ff;
      hit_in   = hit_ff;
      emit_in  = emit_ff;
      mem_req  = '0;
      req_ready  = (state_ff == ST_IDLE);
      done_valid = (state_ff == ST_DONE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               scr_in   = 1'b0;
               hit_in   = 1'b0;
               state_in = ST_DONE;
               case (req_data.action)
                  ttcs_pkg::ACT_PRINT: begin
                     case (req_data.char_code)
                        ttcs_pkg::CH_LF: begin
                           if (last_row) begin
                              scr_in   = 1'b1;
                              cnt_in   = ttcs_pkg::CNT_W'(ttcs_pkg::COLUMNS);
                              state_in = ST_COPY;
                           end else begin
                              row_in = row_ff + ttcs_pkg::ROW_W'(1);
                           end
                        end
                        ttcs_pkg::CH_CR: begin
                           col_in = '0;
                        end
                        ttcs_pkg::CH_BS: begin
                           if (col_ff != '0) begin
                              col_in = col_ff - ttcs_pkg::COL_W'(1);
                           end
                        end
                        ttcs_pkg::CH_CURSOR: begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = cursor_pos;
                           mem_req.wr_data = show_cursor ? ttcs_pkg::GLYPH_ON
                                                         : ttcs_pkg::GLYPH_OFF;
                        end
                        default: begin
                           mem_req.wr_en   = 1'b1;
                           mem_req.wr_addr = cursor_pos;
                           mem_req.wr_data = req_data.char_code;
                           if (req_data.advance) begin
                              if (last_col) begin
                                 col_in = '0;
                                 if (last_row) begin
                                    scr_in   = 1'b1;
                                    cnt_in   = ttcs_pkg::CNT_W'(ttcs_pkg::COLUMNS);
                                    state_in = ST_COPY;
                                 end else begin
                                    row_in = row_ff + ttcs_pkg::ROW_W'(1);
                                 end
                              end else begin
                                 col_in = col_ff + ttcs_pkg::COL_W'(1);
                              end
                           end
                        end
                     endcase
                  end
                  ttcs_pkg::ACT_READ: begin
                     if (32'(req_data.cell_index) < ttcs_pkg::CELLS) begin
                        hit_in          = 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ttcs_pkg::ADDR_W'(req_data.cell_index);
                     end
                  end
                  ttcs_pkg::ACT_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     emit_in  = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (cnt_ff != ttcs_pkg::CNT_W'(ttcs_pkg::CELLS)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cnt_ff[ttcs_pkg::ADDR_W-1:0];
               cnt_in          = cnt_ff + ttcs_pkg::CNT_W'(1);
            end else begin
               cnt_in   = ttcs_pkg::CNT_W'(ttcs_pkg::CELLS - ttcs_pkg::COLUMNS);
               state_in = ST_BOTTOM;
            end
            if (cnt_ff != ttcs_pkg::CNT_W'(ttcs_pkg::COLUMNS)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = copy_dst[ttcs_pkg::ADDR_W-1:0];
               mem_req.wr_data = rd_data;
            end
         end
         ST_BOTTOM, ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff[ttcs_pkg::ADDR_W-1:0];
            mem_req.wr_data = '0;
            if (cnt_ff == ttcs_pkg::CNT_W'(ttcs_pkg::CELLS - 1)) begin
               if (state_ff == ST_BOTTOM || emit_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
               emit_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + ttcs_pkg::CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      done_data.cell_data     = hit_ff ? rd_data : 8'd0;
      done_data.cursor_column = col_ff;
      done_data.cursor_row    = row_ff;
      done_data.scrolled      = scr_ff;
   end

   // reset starts a clearing pass over the buffer that emits no transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         scr_ff   <= 1'b0;
         hit_ff   <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         scr_ff   <= scr_in;
         hit_ff   <= hit_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

### rtl/text_terminal_cursor_scroll.sv
// print without scroll, cell read and action 3 pass through the done state into the result register
// scroll: one buffer cell per cycle, a copy pass moving each line up one row, then a sweep zeroing the bottom row
// clear screen: one cell per cycle over the buffer
// one transaction in flight at a time, paced by the sequencer, which accepts requests only when idle
// reset: synchronous; a clearing pass zeroes the buffer, req_ready low meanwhile
// top level: config register, result register, sequencer and character buffer
module text_terminal_cursor_scroll (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttcs_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);

   logic                  show_cursor_ff, show_cursor_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ttcs_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  done_valid;
   ttcs_pkg::rsp_type     done_data;
   ttcs_pkg::mem_req_type mem_req;
   logic [7:0]            rd_data;

   ttcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .show_cursor (show_cursor_ff),
      .out_free    (out_free),
      .done_valid  (done_valid),
      .done_data   (done_data),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   ttcs_charmem u_charmem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      show_cursor_in = csr_write_en ? csr_write_data : show_cursor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      if (done_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         show_cursor_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         show_cursor_ff <= show_cursor_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // cursor row reported never leaves the buffer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.cursor_row) < ttcs_pkg::ROWS))
      else $error("cursor row out of range");

   // a scrolling transaction always leaves the cursor on the last row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scrolled)
         |-> (32'(rsp_data.cursor_row) == ttcs_pkg::ROWS - 1))
      else $error("scroll with cursor off the last row");

   // a finished result blocked by a full result register is held, not dropped
   assert property (@(posedge clock) disable iff (reset)
      (done_valid && !out_free) |=> done_valid)
      else $error("result lost while output stalled");

   // the clearing pass after reset keeps input closed
   assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input accepted before buffer cleared");

endmodule
